[hdl/i2c_mws_pkg.sv]
package i2c_mws_pkg;

  // field widths
  localparam int ADDR_W  = 8;
  localparam int HALF_W  = 10;
  localparam int TOUT_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT   = 2'd2;

  // reset values of the configuration registers
  localparam logic [ADDR_W-1:0] ADDR_RESET = 8'h78;
  localparam logic [HALF_W-1:0] HALF_RESET = 10'd4;
  localparam logic [TOUT_W-1:0] TOUT_RESET = 10'd250;

  // control bytes sent between the address and the payload
  localparam logic [BYTE_W-1:0] CTRL_COMMAND = 8'h00;
  localparam logic [BYTE_W-1:0] CTRL_DATA    = 8'h40;

  // bits per byte on the wire
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // index of the last byte of the write (address, control, payload)
  localparam logic [1:0] LAST_BYTE = 2'd2;
  localparam logic [1:0] CTRL_BYTE = 2'd1;

  // result bit positions in m_tdata
  localparam int OUT_SCL    = 0;
  localparam int OUT_SDA    = 1;
  localparam int OUT_LISTEN = 2;
  localparam int OUT_BUSY   = 3;
  localparam int OUT_NACK   = 4;

endpackage

[hdl/i2c_master_write_sequencer.sv]
// channel   dir  handshake                beat contents
// s_*       in   s_tvalid / s_tready      one tick: request, payload, sda_in, is_data
// m_*       out  m_tvalid / m_tready      line levels and status for that tick
// cfg_*     in   cfg_valid / cfg_ready    register index and write data
//
// one tick per clock: the sequencer state and the result register update in the
// cycle a tick beat is taken, so the next tick can follow in the next cycle.
// s_tready is low only while a result waits in the output register and m_tready
// is low; cfg_ready is always high. rst is synchronous and returns the
// sequencer to idle with the configuration registers at their defaults.
module i2c_master_write_sequencer
  import i2c_mws_pkg::*;
#(
  parameter int TICK_COUNT_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  // tick in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // request[0], payload[8:1], sda_in[9], zero[15:10]
  input  logic                  s_tuser,   // is_data[0]
  // result out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // scl[0], sda_out[1], sda_listen[2], busy_res[3],
                                           // nacked[4], zero[7:5]
  output logic                  m_tlast,   // done_res[0]
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = ((TICK_COUNT_BITS > HALF_W) ? TICK_COUNT_BITS : HALF_W) + 1;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_BIT_LO,
    PH_BIT_HI,
    PH_ACK_LO,
    PH_ACK_HI,
    PH_STOP_LO,
    PH_STOP_HI,
    PH_STOP_REL
  } phase_t;

  logic [ADDR_W-1:0] dev_addr;
  logic [HALF_W-1:0] half_period;
  logic [TOUT_W-1:0] ack_timeout;

  phase_t                     phase, phase_next;
  logic [3:0]                 bit_count, bit_count_next;
  logic [1:0]                 byte_index, byte_index_next;
  logic [BYTE_W-1:0]          shifter, shifter_next;
  logic [TICK_COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [TICK_COUNT_BITS-1:0] wait_count, wait_count_next;
  logic [BYTE_W-1:0]          held_payload, held_payload_next;
  logic                       held_kind, held_kind_next;
  logic                       aborted, aborted_next;

  logic              in_fire;
  logic              request, sda_in;
  logic [BYTE_W-1:0] payload;
  logic              tick_over, wait_over;
  logic [3:0]        bit_count_inc;
  logic [1:0]        byte_index_inc;
  logic              scl, sda, listen, busy, done, nack;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;

  assign request = s_tdata[0];
  assign payload = s_tdata[8:1];
  assign sda_in  = s_tdata[9];

  // zero registers behave as one since the compare is against count + 1
  assign tick_over = (CW'(tick_count) + CW'(1) >= CW'(half_period)) || (tick_count == '1);
  assign wait_over = (CW'(wait_count) + CW'(1) >= CW'(ack_timeout)) || (wait_count == '1);
  assign bit_count_inc  = bit_count + 4'd1;
  assign byte_index_inc = byte_index + 2'd1;

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    byte_index_next   = byte_index;
    shifter_next      = shifter;
    tick_count_next   = tick_count;
    wait_count_next   = wait_count;
    held_payload_next = held_payload;
    held_kind_next    = held_kind;
    aborted_next      = aborted;
    scl    = 1'b1;
    sda    = 1'b1;
    listen = 1'b0;
    busy   = 1'b1;
    done   = 1'b0;
    nack   = 1'b0;

    case (phase)
      PH_START, PH_BIT_LO, PH_BIT_HI, PH_ACK_LO, PH_STOP_LO, PH_STOP_HI,
      PH_STOP_REL: begin
        tick_count_next = tick_over ? '0 : tick_count + 1'b1;
      end
      default: ;
    endcase

    case (phase)
      PH_START: begin
        sda = 1'b0;
        if (tick_over) begin
          shifter_next    = dev_addr;
          bit_count_next  = '0;
          byte_index_next = '0;
          phase_next      = PH_BIT_LO;
        end
      end
      PH_BIT_LO: begin
        scl = 1'b0;
        sda = shifter[BYTE_W-1];
        if (tick_over) phase_next = PH_BIT_HI;
      end
      PH_BIT_HI: begin
        sda = shifter[BYTE_W-1];
        if (tick_over) begin
          shifter_next   = {shifter[BYTE_W-2:0], 1'b0};
          bit_count_next = bit_count_inc;
          phase_next     = (bit_count_inc >= BITS_PER_BYTE) ? PH_ACK_LO : PH_BIT_LO;
        end
      end
      PH_ACK_LO: begin
        scl    = 1'b0;
        listen = 1'b1;
        if (tick_over) begin
          wait_count_next = '0;
          phase_next      = PH_ACK_HI;
        end
      end
      PH_ACK_HI: begin
        listen = 1'b1;
        if (!sda_in) begin
          wait_count_next = '0;
          tick_count_next = '0;
          if (byte_index >= LAST_BYTE) begin
            phase_next = PH_STOP_LO;
          end else begin
            byte_index_next = byte_index_inc;
            if (byte_index_inc == CTRL_BYTE) begin
              shifter_next = held_kind ? CTRL_DATA : CTRL_COMMAND;
            end else begin
              shifter_next = held_payload;
            end
            bit_count_next = '0;
            phase_next     = PH_BIT_LO;
          end
        end else if (wait_over) begin
          // no acknowledge in time: skip the rest and send stop
          wait_count_next = '0;
          tick_count_next = '0;
          aborted_next    = 1'b1;
          phase_next      = PH_STOP_LO;
        end else begin
          wait_count_next = wait_count + 1'b1;
        end
      end
      PH_STOP_LO: begin
        scl = 1'b0;
        sda = 1'b0;
        if (tick_over) phase_next = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        sda = 1'b0;
        if (tick_over) phase_next = PH_STOP_REL;
      end
      PH_STOP_REL: begin
        if (tick_over) begin
          done         = 1'b1;
          nack         = aborted;
          aborted_next = 1'b0;
          phase_next   = PH_IDLE;
        end
      end
      default: begin
        busy       = 1'b0;
        phase_next = PH_IDLE;
        if (request) begin
          held_payload_next = payload;
          held_kind_next    = s_tuser;
          aborted_next      = 1'b0;
          bit_count_next    = '0;
          byte_index_next   = '0;
          wait_count_next   = '0;
          tick_count_next   = '0;
          phase_next        = PH_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr      <= ADDR_RESET;
      half_period   <= HALF_RESET;
      ack_timeout   <= TOUT_RESET;
      phase         <= PH_IDLE;
      bit_count     <= '0;
      byte_index    <= '0;
      shifter       <= '0;
      tick_count    <= '0;
      wait_count    <= '0;
      held_payload  <= '0;
      held_kind     <= 1'b0;
      aborted       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEV_ADDR:      dev_addr      <= cfg_data[ADDR_W-1:0];
          CFG_HALF_PERIOD:   half_period   <= cfg_data[HALF_W-1:0];
          CFG_ACK_TIMEOUT:   ack_timeout   <= cfg_data[TOUT_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase        <= phase_next;
        bit_count    <= bit_count_next;
        byte_index   <= byte_index_next;
        shifter      <= shifter_next;
        tick_count   <= tick_count_next;
        wait_count   <= wait_count_next;
        held_payload <= held_payload_next;
        held_kind    <= held_kind_next;
        aborted      <= aborted_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result register, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= {3'b000, nack, busy, listen, sda, scl};
      m_tlast <= done;
    end
  end

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[OUT_BUSY])
    else $error("done beat without busy");

  a_nack_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_NACK] |-> m_tlast)
    else $error("nack reported outside the done beat");

  a_listen_released: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_LISTEN] |-> m_tdata[OUT_SDA])
    else $error("sda driven low while listening for ack");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE |=> m_tvalid && !m_tdata[OUT_BUSY])
    else $error("idle tick reported busy");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit counter ran past a byte");
`endif

endmodule

[verif/i2c_mws_checker.sv]
module i2c_mws_checker
  import i2c_mws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // request[0], payload[8:1], sda_in[9], zero[15:10]
  input  logic                  s_tuser,   // is_data[0]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,   // scl[0], sda_out[1], sda_listen[2], busy_res[3],
                                           // nacked[4], zero[7:5]
  input  logic                  m_tlast,   // done_res[0]
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending,
  output logic                  seq_idle,
  output int                    transfers,
  output int                    aborts
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_MAX = (1 << 10) - 1;
  localparam int REPORT_CAP = 40;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START, SEQ_BIT_LO, SEQ_BIT_HI, SEQ_ACK_LO, SEQ_ACK_HI,
    SEQ_STOP_LO, SEQ_STOP_HI, SEQ_STOP_REL
  } seq_state_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic listen;
    logic busy;
    logic done;
    logic nack;
  } line_beat_t;

  // register copies
  logic [ADDR_W-1:0] addr_reg;
  logic [HALF_W-1:0] half_reg;
  logic [TOUT_W-1:0] tout_reg;

  // sequencer copy
  seq_state_t        state;
  logic [3:0]        bit_cnt;
  logic [1:0]        byte_idx;
  logic [BYTE_W-1:0] shift_reg;
  int unsigned       hold_cnt;
  int unsigned       ack_wait;
  logic [BYTE_W-1:0] saved_payload;
  logic              saved_kind;
  logic              abort_flag;

  line_beat_t lines_due[$];
  int err_n = 0;
  int xfer_n = 0;
  int abort_n = 0;

  function automatic bit phase_expired();
    if (hold_cnt + 1 >= half_reg || hold_cnt >= CNT_MAX) begin
      hold_cnt = 0;
      return 1'b1;
    end
    hold_cnt = hold_cnt + 1;
    return 1'b0;
  endfunction

  function automatic void enter_state(seq_state_t s);
    state = s;
    hold_cnt = 0;
  endfunction

  // one tick of the bus sequencer; levels reflect the state before the update
  task automatic predict_tick(input logic req, input logic kind, input logic [7:0] pay,
                              input logic sda_i, output line_beat_t b);
    logic msb;
    msb = shift_reg[7];
    b = '{scl: 1'b1, sda: 1'b1, listen: 1'b0, busy: 1'b1, done: 1'b0, nack: 1'b0};
    case (state)
      SEQ_START: begin
        b.sda = 1'b0;
        if (phase_expired()) begin
          shift_reg = addr_reg;
          bit_cnt = '0;
          byte_idx = '0;
          enter_state(SEQ_BIT_LO);
        end
      end
      SEQ_BIT_LO: begin
        b.scl = 1'b0;
        b.sda = msb;
        if (phase_expired()) enter_state(SEQ_BIT_HI);
      end
      SEQ_BIT_HI: begin
        b.sda = msb;
        if (phase_expired()) begin
          shift_reg = shift_reg << 1;
          bit_cnt = bit_cnt + 4'd1;
          enter_state(bit_cnt >= BITS_PER_BYTE ? SEQ_ACK_LO : SEQ_BIT_LO);
        end
      end
      SEQ_ACK_LO: begin
        b.scl = 1'b0;
        b.listen = 1'b1;
        if (phase_expired()) begin
          ack_wait = 0;
          enter_state(SEQ_ACK_HI);
        end
      end
      SEQ_ACK_HI: begin
        b.listen = 1'b1;
        if (!sda_i) begin
          ack_wait = 0;
          if (byte_idx >= LAST_BYTE) begin
            enter_state(SEQ_STOP_LO);
          end else begin
            byte_idx = byte_idx + 2'd1;
            if (byte_idx == CTRL_BYTE) shift_reg = saved_kind ? CTRL_DATA : CTRL_COMMAND;
            else shift_reg = saved_payload;
            bit_cnt = '0;
            enter_state(SEQ_BIT_LO);
          end
        end else if (ack_wait + 1 >= tout_reg || ack_wait >= CNT_MAX) begin
          // slave never pulled sda low: give up and go to stop
          ack_wait = 0;
          abort_flag = 1'b1;
          enter_state(SEQ_STOP_LO);
        end else begin
          ack_wait = ack_wait + 1;
        end
      end
      SEQ_STOP_LO: begin
        b.scl = 1'b0;
        b.sda = 1'b0;
        if (phase_expired()) enter_state(SEQ_STOP_HI);
      end
      SEQ_STOP_HI: begin
        b.sda = 1'b0;
        if (phase_expired()) enter_state(SEQ_STOP_REL);
      end
      SEQ_STOP_REL: begin
        if (phase_expired()) begin
          b.done = 1'b1;
          b.nack = abort_flag;
          abort_flag = 1'b0;
          enter_state(SEQ_IDLE);
        end
      end
      default: begin
        b.busy = 1'b0;
        state = SEQ_IDLE;
        if (req) begin
          saved_payload = pay;
          saved_kind = kind;
          abort_flag = 1'b0;
          bit_cnt = '0;
          byte_idx = '0;
          ack_wait = 0;
          enter_state(SEQ_START);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic want_v, input logic got_v);
    if (got_v !== want_v) begin
      err_n++;
      if (err_n <= REPORT_CAP)
        $display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    line_beat_t got;
    line_beat_t want;
    if (rst) begin
      addr_reg = ADDR_RESET;
      half_reg = HALF_RESET;
      tout_reg = TOUT_RESET;
      state = SEQ_IDLE;
      bit_cnt = '0;
      byte_idx = '0;
      shift_reg = '0;
      hold_cnt = 0;
      ack_wait = 0;
      saved_payload = '0;
      saved_kind = 1'b0;
      abort_flag = 1'b0;
      lines_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.scl = m_tdata[OUT_SCL];
        got.sda = m_tdata[OUT_SDA];
        got.listen = m_tdata[OUT_LISTEN];
        got.busy = m_tdata[OUT_BUSY];
        got.nack = m_tdata[OUT_NACK];
        got.done = m_tlast;
        if (lines_due.size() == 0) begin
          err_n++;
          if (err_n <= REPORT_CAP)
            $display("%0t ns: result beat with nothing expected, expected none, actual %b",
                     $time, got);
        end else begin
          want = lines_due.pop_front();
          check_field("scl", want.scl, got.scl);
          check_field("sda_out", want.sda, got.sda);
          check_field("sda_listen", want.listen, got.listen);
          check_field("busy", want.busy, got.busy);
          check_field("done", want.done, got.done);
          check_field("nacked", want.nack, got.nack);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEV_ADDR:      addr_reg = cfg_data[ADDR_W-1:0];
          CFG_HALF_PERIOD:   half_reg = cfg_data[HALF_W-1:0];
          CFG_ACK_TIMEOUT:   tout_reg = cfg_data[TOUT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_tick(s_tdata[0], s_tuser, s_tdata[8:1], s_tdata[9], want);
        lines_due.push_back(want);
        if (want.done) begin
          xfer_n++;
          if (want.nack) abort_n++;
        end
      end
    end
    mismatches <= err_n;
    pending <= lines_due.size();
    seq_idle <= (state == SEQ_IDLE);
    transfers <= xfer_n;
    aborts <= abort_n;
  end

endmodule

[verif/i2c_master_write_sequencer_tb.sv]
module i2c_master_write_sequencer_tb
  import i2c_mws_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // request[0], payload[8:1], sda_in[9], zero[15:10]
  logic                  s_tuser = 1'b0; // is_data[0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // scl[0], sda_out[1], sda_listen[2], busy_res[3],
                                         // nacked[4], zero[7:5]
  logic                  m_tlast;        // done_res[0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   mismatches;
  int   pending;
  logic seq_idle;
  int   transfers;
  int   aborts;

  int ticks_sent = 0;
  int settings_n = 0;

  i2c_master_write_sequencer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  i2c_mws_checker line_watch (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .seq_idle(seq_idle),
    .transfers(transfers), .aborts(aborts)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("timeout at %0t ns with %0d result beats outstanding", $time, pending);
    $display("status: fail");
    $finish;
  end

  // receiver backpressure, switching to a randomly chosen style at regular intervals
  rx_mode_t rx_mode = RX_OPEN;
  int rx_age = 0;
  int rx_hold = 0;

  always @(posedge clk) begin
    rx_age++;
    if (rx_age >= 300) begin
      rx_age = 0;
      rx_mode = rx_mode_t'($urandom_range(0, 2));
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: m_tready <= 1'b1;
        RX_COIN: m_tready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(1, 8);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // leaves valid high; callers lower it only when a gap follows
  task automatic send_tick(input logic req, input logic kind, input logic [7:0] pay,
                           input logic sda);
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, sda, pay, req};
    s_tuser <= kind;
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
  endtask

  task automatic pause_until_quiet();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // finish any transfer in flight by acking every byte, one beat at a time
  task automatic settle();
    pause_until_quiet();
    while (!seq_idle) begin
      send_tick(1'b0, 1'b0, 8'h00, 1'b0);
      pause_until_quiet();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input logic [7:0] addr, input logic [9:0] half,
                           input logic [9:0] tout);
    write_reg(CFG_DEV_ADDR, CFG_DATA_W'(addr));
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_ACK_TIMEOUT, tout);
    cfg_valid <= 1'b0;
    settings_n++;
  endtask

  // random ticks in bursts; low_pct sets how often the slave holds sda low
  task automatic run_stream(input int n, input int low_pct);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), $urandom_range(1, 100) > low_pct);
        left--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values: idle beat, a command write, then requests while busy
    send_tick(1'b0, 1'b1, 8'hFF, 1'b1);
    send_tick(1'b1, 1'b0, 8'h00, 1'b0);
    for (int i = 0; i < 18; i++)
      send_tick(1'b1, 1'b1, (i % 2) ? 8'hAA : 8'hFF, 1'b1);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin  // one high sample at the ack aborts
          load_regs(8'h00, 10'd1, 10'd1);
          run_stream(40, 50);
        end
        1: begin  // zero registers behave as one
          load_regs(8'hFF, 10'd0, 10'd0);
          run_stream(40, 70);
        end
        2: begin
          load_regs(8'hA5, 10'd2, 10'd3);
          run_stream(40, 40);
        end
        3: begin  // slave never acks, longer timeout
          load_regs(8'h5A, 10'd1, 10'd30);
          run_stream(40, 0);
        end
        4: begin
          load_regs(8'h81, 10'd1, 10'd2);
          run_stream(40, 80);
        end
        default: begin
          load_regs(8'($urandom_range(0, 255)), 10'($urandom_range(1, 3)),
                    10'($urandom_range(1, 12)));
          run_stream(40, ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(40, 90));
        end
      endcase
      settle();
    end

    repeat (16) @(posedge clk);
    $display("sent %0d tick beats under %0d register settings", ticks_sent, settings_n + 1);
    $display("%0d write transfers completed, %0d of them aborted on a missing ack",
             transfers, aborts);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
